@@ design/lad_pkg.sv @@
package lad_pkg;

	localparam int CHANNELS_DEF = 4;
	localparam int FRAC_BITS_DEF = 16;

	// configuration port
	localparam int CFG_W = 25;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_CTRL_BW    = 3'd0;
	localparam logic [IDX_W-1:0] REG_OBS_BW     = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN       = 3'd2;
	localparam logic [IDX_W-1:0] REG_GAIN_RECIP = 3'd3;
	localparam logic [IDX_W-1:0] REG_STEP_TIME  = 3'd4;
	localparam logic [IDX_W-1:0] REG_DRIVE_LIM  = 3'd5;
	localparam logic [IDX_W-1:0] REG_ALPHA      = 3'd6;

	localparam logic [24:0] RST_CTRL_BW    = 25'd1638400;
	localparam logic [24:0] RST_OBS_BW     = 25'd3932160;
	localparam logic [24:0] RST_GAIN       = 25'd13107;
	localparam logic [24:0] RST_GAIN_RECIP = 25'd327680;
	localparam logic [16:0] RST_STEP_TIME  = 17'd655;
	localparam logic [14:0] RST_DRIVE_LIM  = 15'd1000;
	localparam logic [16:0] RST_ALPHA      = 17'd19661;

	typedef struct packed {
		logic [1:0]         wheel;
		logic signed [31:0] measured_rpm;
		logic signed [31:0] target_rpm;
		logic               operational;
	} in_t;

	typedef struct packed {
		logic [1:0]         wheel_out;
		logic signed [15:0] drive;
		logic               brake;
	} out_t;

	typedef struct packed {
		logic [24:0] ctrl_bandwidth;
		logic [24:0] observer_bandwidth;
		logic [24:0] input_gain;
		logic [24:0] input_gain_recip;
		logic [16:0] step_time;
		logic [14:0] drive_limit;
		logic [16:0] filter_alpha;
	} cfg_t;

	typedef struct packed {
		logic               en;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} mul_req_t;

	typedef struct packed {
		logic signed [63:0] prod;
		logic signed [31:0] mq;
	} mul_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = 66'sd2147483647;
		lo = -66'sd2147483648;
		if (x > hi) return 32'sh7FFFFFFF;
		if (x < lo) return 32'sh80000000;
		return x[31:0];
	endfunction

endpackage

@@ design/lad_mul.sv @@
module lad_mul #(
	parameter int FRAC_BITS = lad_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  lad_pkg::mul_req_t req,
	output lad_pkg::mul_rsp_t rsp
);
	import lad_pkg::*;

	logic signed [31:0] op_a;
	logic signed [31:0] op_b;
	logic signed [63:0] prod_q;
	logic signed [63:0] prod_sh;

	assign op_a = req.a;
	assign op_b = req.b;

	// product holds while no new operation is issued
	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= 64'(op_a) * 64'(op_b);
		end
	end

	// floor shift back to Q format, then saturate
	assign prod_sh  = prod_q >>> FRAC_BITS;
	assign rsp.prod = prod_q;
	assign rsp.mq   = sat32(66'(prod_sh));

endmodule

@@ design/lad_ctrl.sv @@
module lad_ctrl #(
	parameter int CHANNELS  = lad_pkg::CHANNELS_DEF,
	parameter int FRAC_BITS = lad_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lad_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  lad_pkg::in_t      in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output lad_pkg::out_t     out_data,
	output lad_pkg::mul_req_t mul_req,
	input  lad_pkg::mul_rsp_t mul_rsp
);
	import lad_pkg::*;

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_FOLD = 4'd1;
	localparam logic [3:0] S_NEW  = 4'd2;
	localparam logic [3:0] S_BU   = 4'd3;
	localparam logic [3:0] S_B2   = 4'd4;
	localparam logic [3:0] S_B1E  = 4'd5;
	localparam logic [3:0] S_B2E  = 4'd6;
	localparam logic [3:0] S_DZ1H = 4'd7;
	localparam logic [3:0] S_TH   = 4'd8;
	localparam logic [3:0] S_ERR  = 4'd9;
	localparam logic [3:0] S_WC   = 4'd10;
	localparam logic [3:0] S_WCR  = 4'd11;
	localparam logic [3:0] S_RCP  = 4'd12;
	localparam logic [3:0] S_DONE = 4'd13;

	logic [3:0] step_q;
	in_t        item_q;
	logic       out_valid_q;
	out_t       out_q;

	logic signed [31:0] observed_speed_q [CHANNELS];
	logic signed [31:0] observed_disturbance_q [CHANNELS];
	logic signed [31:0] previous_drive_q [CHANNELS];
	logic signed [31:0] filtered_speed_q [CHANNELS];

	logic signed [63:0] acc_q;
	logic signed [31:0] filt_q;
	logic signed [31:0] t1_q;
	logic signed [31:0] e_q;
	logic signed [31:0] beta2_q;
	logic signed [31:0] dz1_q;
	logic signed [31:0] t_q;
	logic signed [31:0] z1n_q;
	logic signed [31:0] z2n_q;
	logic signed [31:0] err_q;
	logic signed [31:0] diff_q;

	logic [CH_W-1:0]    idx;
	logic               in_range;
	logic               in_range_new;
	logic               take_in;
	logic               out_free;
	logic               done_fire;
	logic signed [31:0] z1;
	logic signed [31:0] z2;
	logic signed [31:0] u_prev;
	logic signed [31:0] filt_prev;
	logic signed [31:0] raw;
	logic signed [31:0] target;
	logic signed [31:0] alpha_s;
	logic signed [31:0] alpha_c;
	logic signed [31:0] wo_s;
	logic signed [31:0] beta1;
	logic signed [31:0] h_s;
	logic signed [31:0] b0_s;
	logic signed [31:0] wc_s;
	logic signed [31:0] rcp_s;
	logic signed [63:0] prod;
	logic signed [31:0] mq;
	logic signed [63:0] fsum;
	logic signed [47:0] lim;
	logic signed [47:0] mq48;
	logic signed [47:0] c48;
	logic signed [31:0] cmd;
	logic signed [32:0] c33;
	logic signed [32:0] mag;
	logic signed [32:0] q33;
	logic signed [15:0] drive16;

	assign idx          = CH_W'(item_q.wheel);
	assign in_range     = 32'(item_q.wheel) < 32'(CHANNELS);
	assign in_range_new = 32'(in_data.wheel) < 32'(CHANNELS);

	assign in_stall  = (step_q != S_IDLE);
	assign take_in   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign done_fire = (step_q == S_DONE) && out_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign z1        = observed_speed_q[idx];
	assign z2        = observed_disturbance_q[idx];
	assign u_prev    = previous_drive_q[idx];
	assign filt_prev = filtered_speed_q[idx];
	assign raw       = item_q.measured_rpm;
	assign target    = item_q.target_rpm;

	assign alpha_s = 32'(cfg.filter_alpha);
	assign alpha_c = (alpha_s > ONE_Q) ? ONE_Q : alpha_s;
	assign wo_s    = 32'(cfg.observer_bandwidth);
	assign beta1   = wo_s <<< 1;
	assign h_s     = 32'(cfg.step_time);
	assign b0_s    = 32'(cfg.input_gain);
	assign wc_s    = 32'(cfg.ctrl_bandwidth);
	assign rcp_s   = 32'(cfg.input_gain_recip);

	assign prod = mul_rsp.prod;
	assign mq   = mul_rsp.mq;
	assign fsum = (acc_q + prod) >>> FRAC_BITS;

	// operand selection for the shared multiplier
	always_comb begin
		mul_req = '0;
		unique case (step_q)
			S_FOLD: begin
				mul_req.en = 1'b1;
				mul_req.a  = ONE_Q - alpha_c;
				mul_req.b  = filt_prev;
			end
			S_NEW: begin
				mul_req.en = 1'b1;
				mul_req.a  = alpha_c;
				mul_req.b  = raw;
			end
			S_BU: begin
				mul_req.en = 1'b1;
				mul_req.a  = b0_s;
				mul_req.b  = u_prev;
			end
			S_B2: begin
				mul_req.en = 1'b1;
				mul_req.a  = wo_s;
				mul_req.b  = wo_s;
			end
			S_B1E: begin
				mul_req.en = 1'b1;
				mul_req.a  = beta1;
				mul_req.b  = e_q;
			end
			S_B2E: begin
				mul_req.en = 1'b1;
				mul_req.a  = beta2_q;
				mul_req.b  = e_q;
			end
			S_DZ1H: begin
				mul_req.en = 1'b1;
				mul_req.a  = dz1_q;
				mul_req.b  = h_s;
			end
			S_TH: begin
				mul_req.en = 1'b1;
				mul_req.a  = t_q;
				mul_req.b  = h_s;
			end
			S_WC: begin
				mul_req.en = 1'b1;
				mul_req.a  = wc_s;
				mul_req.b  = err_q;
			end
			S_RCP: begin
				mul_req.en = 1'b1;
				mul_req.a  = diff_q;
				mul_req.b  = rcp_s;
			end
			default: begin
				mul_req = '0;
			end
		endcase
	end

	// clamp to the drive limit and truncate toward zero
	always_comb begin
		lim  = 48'(cfg.drive_limit) << FRAC_BITS;
		mq48 = 48'(mq);
		if (mq48 > lim) begin
			c48 = lim;
		end else if (mq48 < -lim) begin
			c48 = -lim;
		end else begin
			c48 = mq48;
		end
		cmd     = c48[31:0];
		c33     = 33'(cmd);
		mag     = cmd[31] ? -c33 : c33;
		q33     = mag >>> FRAC_BITS;
		drive16 = cmd[31] ? -q33[15:0] : q33[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			unique case (step_q)
				S_IDLE: begin
					if (take_in) begin
						step_q <= (in_data.operational && in_range_new) ? S_FOLD : S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) step_q <= S_IDLE;
				end
				default: begin
					step_q <= step_q + 4'd1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) item_q <= in_data;
	end

	// retire the product issued in the previous step
	always_ff @(posedge clk) begin
		unique case (step_q)
			S_NEW: acc_q <= prod;
			S_BU:  filt_q <= sat32(66'(fsum));
			S_B2: begin
				t1_q <= mq;
				e_q  <= sat32(66'(filt_q) - 66'(z1));
			end
			S_B1E:  beta2_q <= mq;
			S_B2E:  dz1_q <= sat32(66'(z2) + 66'(t1_q) + 66'(mq));
			S_DZ1H: t_q <= mq;
			S_TH:   z1n_q <= sat32(66'(z1) + 66'(mq));
			S_ERR: begin
				z2n_q <= sat32(66'(z2) + 66'(mq));
				err_q <= sat32(66'(target) - 66'(z1n_q));
			end
			S_WCR:  diff_q <= sat32(66'(mq) - 66'(z2n_q));
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				observed_speed_q[i]       <= '0;
				observed_disturbance_q[i] <= '0;
				previous_drive_q[i]       <= '0;
				filtered_speed_q[i]       <= '0;
			end
		end else if (done_fire) begin
			if (!item_q.operational) begin
				// brake clears every channel
				for (int i = 0; i < CHANNELS; i++) begin
					observed_speed_q[i]       <= '0;
					observed_disturbance_q[i] <= '0;
					previous_drive_q[i]       <= '0;
					filtered_speed_q[i]       <= '0;
				end
			end else if (in_range) begin
				observed_speed_q[idx]       <= z1n_q;
				observed_disturbance_q[idx] <= z2n_q;
				previous_drive_q[idx]       <= cmd;
				filtered_speed_q[idx]       <= filt_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			out_q.wheel_out <= item_q.wheel;
			out_q.drive     <= (item_q.operational && in_range) ? drive16 : 16'sd0;
			out_q.brake     <= !item_q.operational;
		end
	end

endmodule

@@ design/four_channel_ladrc_speed_control.sv @@
// four-channel first-order ladrc speed controller
//
// input channel (in_valid / in_stall / in_data): one transfer per control
// sample, naming the wheel, its raw and target speed and the run flag
// output channel (out_valid / out_stall / out_data): exactly one transfer
// per input, in order, carrying wheel, drive and brake
// config port (cfg_we / cfg_index / cfg_data): single-cycle register writes;
// the user must write only while no item is in flight, the block does not enforce it
//
// a running item walks ten products through one shared 32x32 multiplier
// under a step sequencer; out_valid is registered as the item leaves its
// last step, and the block takes no new item until the sequencer is back
// in idle; a not-running or unknown-wheel item goes straight to its last step
// a result waiting under out_stall holds its register while the next item
// is taken; a finished item then waits in its last step until the slot frees
// reset clears all channel states, loads default gains and empties the
// output register; dropping the run flag clears every channel and brakes
module four_channel_ladrc_speed_control #(
	parameter int CHANNELS  = lad_pkg::CHANNELS_DEF,
	parameter int FRAC_BITS = lad_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  lad_pkg::in_t              in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output lad_pkg::out_t             out_data,
	input  logic                      cfg_we,
	input  logic [lad_pkg::IDX_W-1:0] cfg_index,
	input  logic [lad_pkg::CFG_W-1:0] cfg_data
);
	import lad_pkg::*;

	cfg_t     cfg_q;
	mul_req_t mul_req;
	mul_rsp_t mul_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ctrl_bandwidth     <= RST_CTRL_BW;
			cfg_q.observer_bandwidth <= RST_OBS_BW;
			cfg_q.input_gain         <= RST_GAIN;
			cfg_q.input_gain_recip   <= RST_GAIN_RECIP;
			cfg_q.step_time          <= RST_STEP_TIME;
			cfg_q.drive_limit        <= RST_DRIVE_LIM;
			cfg_q.filter_alpha       <= RST_ALPHA;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CTRL_BW:    cfg_q.ctrl_bandwidth     <= cfg_data;
				REG_OBS_BW:     cfg_q.observer_bandwidth <= cfg_data;
				REG_GAIN:       cfg_q.input_gain         <= cfg_data;
				REG_GAIN_RECIP: cfg_q.input_gain_recip   <= cfg_data;
				REG_STEP_TIME:  cfg_q.step_time          <= cfg_data[16:0];
				REG_DRIVE_LIM:  cfg_q.drive_limit        <= cfg_data[14:0];
				REG_ALPHA:      cfg_q.filter_alpha       <= cfg_data[16:0];
				default: begin
				end
			endcase
		end
	end

	lad_ctrl #(
		.CHANNELS  (CHANNELS),
		.FRAC_BITS (FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.mul_req   (mul_req),
		.mul_rsp   (mul_rsp)
	);

	lad_mul #(
		.FRAC_BITS (FRAC_BITS)
	) u_mul (
		.clk (clk),
		.req (mul_req),
		.rsp (mul_rsp)
	);

endmodule

@@ design/lad_checker.sv @@
module lad_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input lad_pkg::out_t out_data
);
	import lad_pkg::*;

	// an accepted item always keeps the input stalled in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again right after a transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped while stalled");

	a_brake_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.brake) |-> (out_data.drive == 16'sd0))
		else $error("brake result with nonzero drive");

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.drive != 16'sh8000))
		else $error("drive outside the clamp range");

	// a new result only appears as an item finishes
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without an item in flight");

endmodule

bind four_channel_ladrc_speed_control lad_checker u_lad_checker (.*);

@@ bench/testbench.sv @@
module testbench;

	localparam int FRAC = lad_pkg::FRAC_BITS_DEF;
	localparam int WHEELS = lad_pkg::CHANNELS_DEF;
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	lad_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	lad_pkg::out_t out_data;
	logic cfg_we = 1'b0;
	logic [lad_pkg::IDX_W-1:0] cfg_index = '0;
	logic [lad_pkg::CFG_W-1:0] cfg_data = '0;

	// controller copy: gains and per-wheel observer state
	lad_pkg::cfg_t gains;
	longint est_speed [WHEELS];
	longint est_dist [WHEELS];
	longint last_cmd [WHEELS];
	longint filt_speed [WHEELS];

	lad_pkg::out_t pending_drives [$];
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int brakes_seen = 0;
	int reg_writes = 0;
	int burst_left = 0;

	four_channel_ladrc_speed_control uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic longint clip32(input longint x);
		if (x > Q_MAX) return Q_MAX;
		if (x < Q_MIN) return Q_MIN;
		return x;
	endfunction

	// q-format product, floor on the shift
	function automatic longint qmul(input longint a, input longint b);
		return clip32((clip32(a) * clip32(b)) >>> FRAC);
	endfunction

	function automatic void clear_wheels();
		for (int i = 0; i < WHEELS; i++) begin
			est_speed[i] = 0;
			est_dist[i] = 0;
			last_cmd[i] = 0;
			filt_speed[i] = 0;
		end
	endfunction

	function automatic lad_pkg::out_t predict_drive(input lad_pkg::in_t item);
		longint one, a, wo, beta1, beta2, h, z1, z2, u, raw, tgt;
		longint filt, err, dz1, u0, cmd, lim, drv;
		int w;
		lad_pkg::out_t res;
		one = longint'(1) <<< FRAC;
		w = int'(item.wheel);
		res.wheel_out = item.wheel;
		res.drive = '0;
		res.brake = 1'b0;
		if (!item.operational) begin
			clear_wheels();
			res.brake = 1'b1;
		end else if (w < WHEELS) begin
			a = longint'(gains.filter_alpha);
			if (a > one) a = one;
			wo = longint'(gains.observer_bandwidth);
			beta1 = clip32(2 * wo);
			beta2 = qmul(wo, wo);
			h = longint'(gains.step_time);
			z1 = est_speed[w];
			z2 = est_dist[w];
			u = last_cmd[w];
			raw = longint'($signed(item.measured_rpm));
			tgt = longint'($signed(item.target_rpm));

			filt = clip32(((one - a) * filt_speed[w] + a * raw) >>> FRAC);
			filt_speed[w] = filt;

			err = clip32(filt - z1);
			dz1 = clip32(z2 + qmul(longint'(gains.input_gain), u) + qmul(beta1, err));
			z1 = clip32(z1 + qmul(dz1, h));
			z2 = clip32(z2 + qmul(qmul(beta2, err), h));

			u0 = qmul(longint'(gains.ctrl_bandwidth), clip32(tgt - z1));
			cmd = qmul(clip32(u0 - z2), longint'(gains.input_gain_recip));
			lim = longint'(gains.drive_limit) * one;
			if (cmd > lim) cmd = lim;
			if (cmd < -lim) cmd = -lim;

			est_speed[w] = z1;
			est_dist[w] = z2;
			last_cmd[w] = cmd;

			// truncate toward zero
			drv = (cmd >= 0) ? (cmd >>> FRAC) : -((-cmd) >>> FRAC);
			res.drive = drv[15:0];
		end
		return res;
	endfunction

	function automatic lad_pkg::in_t mk(input logic [1:0] w, input logic [31:0] m,
			input logic [31:0] t, input logic op);
		lad_pkg::in_t it;
		it.wheel = w;
		it.measured_rpm = m;
		it.target_rpm = t;
		it.operational = op;
		return it;
	endfunction

	function automatic logic [31:0] rand_speed();
		int whole;
		whole = int'($urandom_range(0, 8000)) - 4000;
		case ($urandom_range(0, 7))
			0: return $urandom();
			1: return 32'h7FFFFFFF - $urandom_range(0, 255);
			2: return 32'h80000000 + $urandom_range(0, 255);
			default: return (whole <<< 16) | $urandom_range(0, 65535);
		endcase
	endfunction

	task automatic send_item(input lad_pkg::in_t item);
		int gap;
		@(negedge clk);
		cfg_we = 1'b0;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		in_data = item;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_drives.push_back(predict_drive(item));
		items_sent++;
	endtask

	task automatic settle();
		@(negedge clk);
		cfg_we = 1'b0;
		in_valid = 1'b0;
		burst_left = 0;
		while (pending_drives.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// cfg_we is lowered by whatever drives the next negedge
	task automatic write_reg(input logic [lad_pkg::IDX_W-1:0] idx, input logic [24:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(posedge clk);
		case (idx)
			lad_pkg::REG_CTRL_BW: gains.ctrl_bandwidth = value;
			lad_pkg::REG_OBS_BW: gains.observer_bandwidth = value;
			lad_pkg::REG_GAIN: gains.input_gain = value;
			lad_pkg::REG_GAIN_RECIP: gains.input_gain_recip = value;
			lad_pkg::REG_STEP_TIME: gains.step_time = value[16:0];
			lad_pkg::REG_DRIVE_LIM: gains.drive_limit = value[14:0];
			lad_pkg::REG_ALPHA: gains.filter_alpha = value[16:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic load_gains(input logic [24:0] wc, input logic [24:0] wo,
			input logic [24:0] b0, input logic [24:0] rb0, input logic [24:0] h,
			input logic [24:0] lim, input logic [24:0] alpha);
		write_reg(lad_pkg::REG_CTRL_BW, wc);
		write_reg(lad_pkg::REG_OBS_BW, wo);
		write_reg(lad_pkg::REG_GAIN, b0);
		write_reg(lad_pkg::REG_GAIN_RECIP, rb0);
		write_reg(lad_pkg::REG_STEP_TIME, h);
		write_reg(lad_pkg::REG_DRIVE_LIM, lim);
		write_reg(lad_pkg::REG_ALPHA, alpha);
	endtask

	// mostly steady runs per target with jitter, some noise and brake drops
	task automatic run_traffic(input int count);
		logic [31:0] aim [WHEELS];
		logic [31:0] spd;
		int len, w, done;
		done = 0;
		while (done < count) begin
			len = $urandom_range(4, 24);
			for (int i = 0; i < WHEELS; i++) aim[i] = rand_speed();
			for (int k = 0; k < len && done < count; k++) begin
				w = ($urandom_range(0, 1) == 0) ? k % WHEELS : $urandom_range(0, WHEELS - 1);
				if ($urandom_range(0, 24) == 0) begin
					send_item(mk(2'($urandom()), $urandom(), $urandom(), 1'($urandom())));
				end else begin
					if ($urandom_range(0, 5) == 0)
						spd = rand_speed();
					else
						spd = aim[w] + 32'($urandom_range(0, 1 << 21)) - 32'd1048576;
					send_item(mk(2'(w), spd, aim[w], 1'b1));
				end
				done++;
			end
		end
	endtask

	task automatic test_field_extremes();
		send_item(mk(2'd0, 32'h00000000, 32'h00000000, 1'b1));
		send_item(mk(2'd1, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1));
		send_item(mk(2'd2, 32'h80000000, 32'h80000000, 1'b1));
		send_item(mk(2'd3, 32'h7FFFFFFF, 32'h80000000, 1'b1));
		send_item(mk(2'd3, 32'h80000000, 32'h7FFFFFFF, 1'b1));
		send_item(mk(2'd1, 32'hFFFFFFFF, 32'h55555555, 1'b1));
		send_item(mk(2'd0, 32'hAAAAAAAA, 32'hFFFFFFFF, 1'b1));
		// brake with extreme values on the other fields
		send_item(mk(2'd2, 32'h7FFFFFFF, 32'h80000000, 1'b0));
		send_item(mk(2'd1, 32'h03E80000, 32'h04B00000, 1'b1));
		send_item(mk(2'd1, 32'h03E80000, 32'h04B00000, 1'b1));
	endtask

	task automatic test_zero_gains();
		settle();
		write_reg(lad_pkg::REG_GAIN, 25'd0);
		write_reg(lad_pkg::REG_GAIN_RECIP, 25'd0);
		send_item(mk(2'd2, 32'h01000000, 32'h7FFFFFFF, 1'b1));
		send_item(mk(2'd2, 32'h80000000, 32'h02000000, 1'b1));
		settle();
		write_reg(lad_pkg::REG_GAIN, 25'd13107);
		write_reg(lad_pkg::REG_GAIN_RECIP, 25'd327680);
		write_reg(lad_pkg::REG_DRIVE_LIM, 25'd0);
		send_item(mk(2'd3, 32'h00000000, 32'h7FFFFFFF, 1'b1));
		settle();
		write_reg(lad_pkg::REG_DRIVE_LIM, 25'd32767);
		send_item(mk(2'd3, 32'h00000000, 32'h7FFFFFFF, 1'b1));
		send_item(mk(2'd0, 32'h00000000, 32'h80000000, 1'b1));
	endtask

	task automatic test_filter_weight();
		settle();
		// weight above one saturates to a full new sample
		write_reg(lad_pkg::REG_ALPHA, 25'd131071);
		send_item(mk(2'd0, 32'h012C0000, 32'h00C80000, 1'b1));
		send_item(mk(2'd0, 32'hFED40000, 32'h00C80000, 1'b1));
		settle();
		write_reg(lad_pkg::REG_ALPHA, 25'd65536);
		send_item(mk(2'd1, 32'h7FFFFFFF, 32'h00000000, 1'b1));
		settle();
		write_reg(lad_pkg::REG_ALPHA, 25'd0);
		send_item(mk(2'd1, 32'h7FFFFFFF, 32'h00000000, 1'b1));
		send_item(mk(2'd2, 32'h80000000, 32'h00640000, 1'b1));
	endtask

	task automatic test_random_settings();
		for (int p = 0; p < 5; p++) begin
			settle();
			case (p)
				0: load_gains(lad_pkg::RST_CTRL_BW, lad_pkg::RST_OBS_BW, lad_pkg::RST_GAIN,
					lad_pkg::RST_GAIN_RECIP, 25'(lad_pkg::RST_STEP_TIME),
					25'(lad_pkg::RST_DRIVE_LIM), 25'(lad_pkg::RST_ALPHA));
				1: load_gains(25'd16777216, 25'd16777216, 25'd16777216, 25'd16777216,
					25'd65536, 25'd32767, 25'd65536);
				2: load_gains(25'd0, 25'd0, 25'd1, 25'd1, 25'd1, 25'd1, 25'd0);
				3: load_gains(25'($urandom_range(0, 16777216)),
					25'($urandom_range(0, 16777216)),
					25'($urandom_range(1, 16777216)), 25'($urandom_range(1, 16777216)),
					25'($urandom_range(1, 65536)), 25'($urandom_range(1, 32767)),
					25'($urandom_range(0, 65536)));
				default: load_gains(25'($urandom_range(1, 100) << 16),
					25'($urandom_range(1, 200) << 16),
					25'($urandom_range(1, 131072)), 25'($urandom_range(1, 1 << 20)),
					25'($urandom_range(100, 2000)), 25'($urandom_range(100, 32767)),
					25'($urandom_range(0, 65536)));
			endcase
			run_traffic(90);
		end
	endtask

	initial begin : rx_pattern
		int mode, len;
		forever begin
			mode = $urandom_range(0, 2);
			len = $urandom_range(10, 60);
			repeat (len) begin
				@(negedge clk);
				case (mode)
					0: out_stall = 1'b0;
					1: out_stall = ($urandom_range(0, 9) < 4);
					default: if ($urandom_range(0, 5) == 0) out_stall = ~out_stall;
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_check
		lad_pkg::out_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (out_data.brake) brakes_seen++;
			if (pending_drives.size() == 0) begin
				errors++;
				$error("unexpected transfer: wheel_out %0d drive %0d brake %0d",
					out_data.wheel_out, $signed(out_data.drive), out_data.brake);
			end else begin
				want = pending_drives.pop_front();
				if (out_data.wheel_out !== want.wheel_out) begin
					errors++;
					$error("wheel_out: expected %0d, actual %0d", want.wheel_out,
						out_data.wheel_out);
				end
				if (out_data.drive !== want.drive) begin
					errors++;
					$error("drive: expected %0d, actual %0d", $signed(want.drive),
						$signed(out_data.drive));
				end
				if (out_data.brake !== want.brake) begin
					errors++;
					$error("brake: expected %0d, actual %0d", want.brake, out_data.brake);
				end
			end
		end
	end

	initial begin : watchdog
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		gains.ctrl_bandwidth = lad_pkg::RST_CTRL_BW;
		gains.observer_bandwidth = lad_pkg::RST_OBS_BW;
		gains.input_gain = lad_pkg::RST_GAIN;
		gains.input_gain_recip = lad_pkg::RST_GAIN_RECIP;
		gains.step_time = lad_pkg::RST_STEP_TIME;
		gains.drive_limit = lad_pkg::RST_DRIVE_LIM;
		gains.filter_alpha = lad_pkg::RST_ALPHA;
		clear_wheels();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_field_extremes();
		test_zero_gains();
		test_filter_weight();
		test_random_settings();
		settle();

		$display("%0d speed samples across %0d register writes, %0d drive results checked",
			items_sent, reg_writes, results_seen);
		$display("%0d braking results, %0d mismatches", brakes_seen, errors);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ four_channel_ladrc_speed_control.f @@
design/lad_pkg.sv
design/lad_mul.sv
design/lad_ctrl.sv
design/four_channel_ladrc_speed_control.sv
design/lad_checker.sv
bench/testbench.sv
